// File: rtl/sdf_pkg.sv
// Shared types, codes and helpers for the separator delimited framer.
package sdf_pkg;

    // Largest separator the block supports, in bytes.
    localparam int MAX_SEP_LEN = 8;

    // Widths that follow from the fixed field sizes.
    localparam int SEP_W   = 8 * MAX_SEP_LEN;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 3;
    localparam int LEN_W   = 4;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Result kinds carried on the output tuser.
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVF  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_CAP    = 2'd2;

    // Configuration reset values (CR then LF, two bytes, 256 byte buffer).
    localparam logic [SEP_W-1:0] SEP_BYTES_RST  = 64'h0000_0000_0000_0A0D;
    localparam logic [LEN_W-1:0] SEP_LENGTH_RST = 4'd2;
    localparam logic [CNT_W-1:0] BUF_CAP_RST    = 16'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take the request byte and clamp the match count
        logic advance;    // partial separator match grew by one byte
        logic start_rel;  // begin releasing held bytes after a mismatch
        logic emit_end;   // emit the separator end-of-frame result
        logic emit_rel;   // emit one release step (data byte or overflow)
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_zero;    // request byte is zero and is ignored
        logic hit;        // byte matches the next separator byte
        logic complete;   // that match completes the separator
        logic out_free;   // output register can take a result this cycle
        logic ovf;        // next released byte does not fit in the frame
        logic rel_last;   // current release step is the final one
    } t_dp_status;

    // Byte i of the separator register.
    function automatic logic [7:0] sep_byte(input logic [SEP_W-1:0] sep,
                                            input logic [IDX_W-1:0] idx);
        sep_byte = sep[{idx, 3'b000} +: 8];
    endfunction

endpackage

// File: rtl/sdf_datapath.sv
// Datapath of the framer: configuration, match state, suffix search and result register.
module sdf_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_cfg_we,
    input  logic [sdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdf_pkg::SEP_W-1:0]     i_cfg_data,
    input  logic                          i_out_ready,
    input  sdf_pkg::t_ctrl_cmd            i_cmd,
    output sdf_pkg::t_dp_status           o_status,
    output logic                          o_out_valid,
    output logic [7:0]                    o_out_byte,
    output logic [sdf_pkg::KIND_W-1:0]    o_kind,
    output logic [sdf_pkg::CNT_W-1:0]     o_frame_length,
    output logic                          o_last
);

    // Configuration registers.
    logic [sdf_pkg::SEP_W-1:0] r_sep;
    logic [sdf_pkg::LEN_W-1:0] r_len;
    logic [sdf_pkg::CNT_W-1:0] r_cap;

    // Match state and per-request working registers.
    logic [sdf_pkg::IDX_W-1:0] r_matched;
    logic [sdf_pkg::CNT_W-1:0] r_pc;
    logic [7:0]                r_byte;
    logic [sdf_pkg::IDX_W-1:0] r_keep;
    logic [sdf_pkg::IDX_W-1:0] r_idx;
    logic [sdf_pkg::LEN_W-1:0] r_rel;

    // Output register.
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic [sdf_pkg::KIND_W-1:0] r_kind;
    logic [sdf_pkg::CNT_W-1:0]  r_flen;
    logic                       r_last;

    logic [sdf_pkg::LEN_W-1:0] eff_len;
    logic [sdf_pkg::IDX_W-1:0] m_clamp;
    logic [sdf_pkg::IDX_W-1:0] keep;
    logic [sdf_pkg::IDX_W-1:0] m_next;
    logic [7:0]                rel_byte;
    logic                      hit;
    logic                      complete;
    logic                      ovf;
    logic                      rel_last;
    logic                      out_free;

    // Effective separator length clamped to 1..MAX_SEP_LEN.
    always_comb begin
        if (r_len == '0) begin
            eff_len = sdf_pkg::LEN_W'(1);
        end else if (r_len > sdf_pkg::LEN_W'(sdf_pkg::MAX_SEP_LEN)) begin
            eff_len = sdf_pkg::LEN_W'(sdf_pkg::MAX_SEP_LEN);
        end else begin
            eff_len = r_len;
        end
    end

    // Held count is kept below the effective length after a config change.
    always_comb begin
        if ({1'b0, r_matched} >= eff_len) begin
            m_clamp = sdf_pkg::IDX_W'(eff_len - sdf_pkg::LEN_W'(1));
        end else begin
            m_clamp = r_matched;
        end
    end

    // Match test on the registered byte against the next separator byte.
    assign hit      = (sdf_pkg::sep_byte(r_sep, r_matched) == r_byte);
    assign complete = (({1'b0, r_matched} + sdf_pkg::LEN_W'(1)) == eff_len);
    assign m_next   = r_matched + sdf_pkg::IDX_W'(1);

    // Longest suffix of (held bytes, new byte) that is a proper separator prefix.
    // Each candidate length is checked independently; the largest that fits wins.
    always_comb begin
        logic                      ok;
        logic [sdf_pkg::LEN_W-1:0] pos;
        keep = '0;
        for (int k = 1; k < sdf_pkg::MAX_SEP_LEN; k++) begin
            ok = (sdf_pkg::IDX_W'(k) <= r_matched) &&
                 (r_byte == sdf_pkg::sep_byte(r_sep, sdf_pkg::IDX_W'(k - 1)));
            for (int j = 0; j < sdf_pkg::MAX_SEP_LEN - 1; j++) begin
                pos = {1'b0, r_matched} - sdf_pkg::LEN_W'(k) + sdf_pkg::LEN_W'(1 + j);
                if (j < k - 1) begin
                    ok = ok && (sdf_pkg::sep_byte(r_sep, pos[sdf_pkg::IDX_W-1:0]) ==
                                sdf_pkg::sep_byte(r_sep, sdf_pkg::IDX_W'(j)));
                end
            end
            if (ok) begin
                keep = sdf_pkg::IDX_W'(k);
            end
        end
    end

    // Release step: held separator bytes first, then the new byte.
    assign rel_byte = (r_idx < r_matched) ? sdf_pkg::sep_byte(r_sep, r_idx) : r_byte;
    assign rel_last = (({1'b0, r_idx} + sdf_pkg::LEN_W'(1)) == r_rel);
    assign ovf      = (({1'b0, r_pc} + 17'd1) >= {1'b0, r_cap});
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.in_zero  = (i_rx_byte == 8'd0);
        o_status.hit      = hit;
        o_status.complete = complete;
        o_status.out_free = out_free;
        o_status.ovf      = ovf;
        o_status.rel_last = rel_last;
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= sdf_pkg::SEP_BYTES_RST;
            r_len <= sdf_pkg::SEP_LENGTH_RST;
            r_cap <= sdf_pkg::BUF_CAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdf_pkg::CFG_SEP_BYTES:  r_sep <= i_cfg_data;
                sdf_pkg::CFG_SEP_LENGTH: r_len <= i_cfg_data[sdf_pkg::LEN_W-1:0];
                sdf_pkg::CFG_BUF_CAP:    r_cap <= i_cfg_data[sdf_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Match count and payload count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched <= '0;
            r_pc      <= '0;
        end else if (i_cmd.load) begin
            r_matched <= m_clamp;
        end else if (i_cmd.advance) begin
            r_matched <= m_next;
        end else if (i_cmd.emit_end) begin
            r_matched <= '0;
            r_pc      <= '0;
        end else if (i_cmd.emit_rel) begin
            if (ovf) begin
                r_matched <= '0;
                r_pc      <= '0;
            end else begin
                r_pc <= r_pc + sdf_pkg::CNT_W'(1);
                if (rel_last) begin
                    r_matched <= r_keep;
                end
            end
        end
    end

    // Request byte and release sequencing registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.start_rel) begin
            r_keep <= keep;
            r_idx  <= '0;
            r_rel  <= {1'b0, r_matched} + sdf_pkg::LEN_W'(1) - {1'b0, keep};
        end else if (i_cmd.emit_rel) begin
            r_idx <= r_idx + sdf_pkg::IDX_W'(1);
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_end || i_cmd.emit_rel) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_end) begin
            r_out_byte <= 8'd0;
            r_kind     <= sdf_pkg::KIND_SEP;
            r_flen     <= r_pc;
            r_last     <= 1'b1;
        end else if (i_cmd.emit_rel) begin
            if (ovf) begin
                r_out_byte <= 8'd0;
                r_kind     <= sdf_pkg::KIND_OVF;
                r_flen     <= r_pc;
                r_last     <= 1'b1;
            end else begin
                r_out_byte <= rel_byte;
                r_kind     <= sdf_pkg::KIND_DATA;
                r_flen     <= '0;
                r_last     <= rel_last;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_kind         = r_kind;
    assign o_frame_length = r_flen;
    assign o_last         = r_last;

    // A finished frame always leaves both counts cleared.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_end |=> (r_matched == '0) && (r_pc == '0))
        else $error("separator end did not clear the frame state");

    // An overflow step drops the frame and clears the payload count.
    a_ovf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_rel && ovf) |=> (r_pc == '0) && r_last && (r_kind == sdf_pkg::KIND_OVF))
        else $error("overflow step did not end the frame");

    // A released data byte never pushes the frame past capacity minus one.
    a_cap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_rel && !ovf) |=> (r_pc < r_cap))
        else $error("payload count passed the buffer capacity");

endmodule

// File: rtl/sdf_ctrl.sv
// Controller state machine of the framer: request intake, match decision and release sequencing.
module sdf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sdf_pkg::t_dp_status  i_status,
    output sdf_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_EVAL    = 4'b0010,
        ST_SEP_END = 4'b0100,
        ST_RELEASE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_status.in_zero) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.hit && i_status.complete) begin
                    n_state = ST_SEP_END;
                end else if (i_status.hit) begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    o_cmd.start_rel = 1'b1;
                    n_state         = ST_RELEASE;
                end
            end
            ST_SEP_END: begin
                if (i_status.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_RELEASE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_rel = 1'b1;
                    if (i_status.ovf || i_status.rel_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted nonzero byte is always evaluated in the next cycle.
    a_load_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && !i_status.in_zero) |=> (r_state == ST_EVAL))
        else $error("accepted byte was not evaluated");

    // Results are only emitted into a free output register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_end || o_cmd.emit_rel) |-> i_status.out_free)
        else $error("result emitted over a waiting result");

    // A mismatch always leads into the release sequence.
    a_miss_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && !i_status.hit) |=> (r_state == ST_RELEASE))
        else $error("mismatch did not start a release");

endmodule

// File: rtl/separator_delimited_framer.sv
// Top level of the separator delimited framer: ports and the controller/datapath pair.
// Received bytes are split into frames at a configured separator of one to eight bytes;
// payload bytes are released as soon as they cannot start a separator, a completed
// separator gives one end-of-frame result with the frame length, and a byte that does
// not fit in capacity minus one ends the frame with an overflow result. A zero byte is
// taken with no result. A byte that extends a partial match passes through intake and
// evaluation. A byte that completes the separator also passes through the separator end
// state, and a mismatching byte is followed by one release step for each released byte
// (one to eight), since every result passes through a single output register one per
// cycle while the output is free; a stalled output holds the release and separator end.
module separator_delimited_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] rx_byte
    // Output stream.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [23:0]                   o_m_axis_tdata,   // [7:0] out_byte, [23:8] frame_length
    output logic [sdf_pkg::KIND_W-1:0]    o_m_axis_tuser,   // [1:0] kind
    output logic                          o_m_axis_tlast,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [sdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdf_pkg::SEP_W-1:0]     i_cfg_data
);

    sdf_pkg::t_ctrl_cmd  cmd;
    sdf_pkg::t_dp_status status;
    logic [7:0]                out_byte;
    logic [sdf_pkg::CNT_W-1:0] frame_length;

    sdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sdf_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_s_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_axis_tready),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_byte     (out_byte),
        .o_kind         (o_m_axis_tuser),
        .o_frame_length (frame_length),
        .o_last         (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {frame_length, out_byte};

endmodule
